// ===== hw/rtl/voxel_grid_ray_traversal_unit_assert.svh =====
// assertion macros for the voxel grid ray traversal unit
// used by the port checker; no other dependencies
`ifndef VOXEL_GRID_RAY_TRAVERSAL_UNIT_ASSERT_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_UNIT_ASSERT_SVH

// same-cycle implication
`define VGRT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vgrt assertion failed");

// next-cycle implication
`define VGRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vgrt assertion failed");

`endif

// ===== hw/rtl/vgrt_pkg.sv =====
// shared types and constants for the voxel grid ray traversal unit
// no dependencies
package vgrt_pkg;

  localparam int CELL_BITS     = 16;
  localparam int STEP_BITS     = 6;
  localparam int TIME_BITS     = 48;
  localparam int DIVIDEND_BITS = 32;
  localparam int DIVISOR_BITS  = 16;
  localparam int DIV_ITERS     = DIVIDEND_BITS / 2;
  localparam int DIV_CNT_BITS  = $clog2(DIV_ITERS);

  localparam logic [TIME_BITS-1:0]     TIME_NEVER   = '1;
  localparam logic [DIVIDEND_BITS-1:0] INC_DIVIDEND = DIVIDEND_BITS'(64'd1 << 31);

  typedef enum logic [1:0] {
    SGN_NONE  = 2'd0,
    SGN_PLUS  = 2'd1,
    SGN_MINUS = 2'd3
  } sgn_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_STEP,
    ST_FLAG
  } state_t;

  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [DIVISOR_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [DIVIDEND_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== hw/rtl/vgrt_div.sv =====
// shared unsigned restoring divider, two quotient bits per cycle
// depends on vgrt_pkg
module vgrt_div (
  input  logic              clk,
  input  logic              rst,
  input  vgrt_pkg::div_req_t req,
  output vgrt_pkg::div_rsp_t rsp
);
  import vgrt_pkg::*;

  logic                     busy;
  logic                     done;
  logic [DIV_CNT_BITS-1:0]  cnt;
  logic [DIVISOR_BITS-1:0]  divisor;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVIDEND_BITS-1:0] quo;

  logic [DIVISOR_BITS:0]    r1;
  logic [DIVISOR_BITS:0]    r1s;
  logic [DIVISOR_BITS:0]    r2;
  logic [DIVISOR_BITS:0]    r2s;
  logic                     ge1;
  logic                     ge2;

  always_comb begin
    r1  = {rem, quo[DIVIDEND_BITS-1]};
    ge1 = (r1 >= {1'b0, divisor});
    r1s = ge1 ? (r1 - {1'b0, divisor}) : r1;
    r2  = {r1s[DIVISOR_BITS-1:0], quo[DIVIDEND_BITS-2]};
    ge2 = (r2 >= {1'b0, divisor});
    r2s = ge2 ? (r2 - {1'b0, divisor}) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == '0);
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= DIV_CNT_BITS'(DIV_ITERS - 1);
        divisor <= req.divisor;
        rem     <= '0;
        quo     <= req.dividend;
      end else if (busy) begin
        rem <= r2s[DIVISOR_BITS-1:0];
        quo <= {quo[DIVIDEND_BITS-3:0], ge1, ge2};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== hw/rtl/voxel_grid_ray_traversal_unit.sv =====
// top level of the voxel grid ray traversal unit: setup sequencer and stepper
// depends on vgrt_pkg and vgrt_div
//
//   channel  handshake               payload
//   cfg      cfg_write               cfg_wdata (max_steps_minus_one)
//   in       in_valid / in_ready     origin_x/y/z, dir_x/y/z
//   out      out_valid / out_ready   cell_x/y/z, entry_face, step_number, no_direction, last
//
// setup runs two divisions per moving axis on the shared divider, then one traversal step
// per cycle while the output register is free, max_steps_minus_one+1 steps
// in_ready is high only while idle; one ray is worked on at a time
// a step waits while the output register holds an untaken result
// reset restores max_steps_minus_one to 16 and empties the output register
module voxel_grid_ray_traversal_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [5:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  origin_x,
  input  logic signed [31:0]  origin_y,
  input  logic signed [31:0]  origin_z,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  cell_x,
  output logic signed [15:0]  cell_y,
  output logic signed [15:0]  cell_z,
  output logic [2:0]          entry_face,
  output logic [5:0]          step_number,
  output logic                no_direction,
  output logic                last
);
  import vgrt_pkg::*;

  state_t state;
  state_t state_next;

  logic [STEP_BITS-1:0]    max_m1;
  logic [STEP_BITS-1:0]    step;
  axis_t                   setup_ax;
  logic                    setup_inc;

  logic [CELL_BITS-1:0]    cur_cell [3];
  logic [TIME_BITS-1:0]    tnext [3];
  logic [TIME_BITS-1:0]    tinc [3];
  sgn_t                    sgn [3];
  logic [15:0]             frac [3];
  logic [DIVISOR_BITS-1:0] mag [3];

  logic signed [31:0]      org_in [3];
  logic signed [15:0]      dir_in [3];

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    accept;
  logic                    all_zero;
  logic                    out_free;
  logic                    do_never;
  logic                    do_div_write;
  logic                    do_step;
  logic                    do_flag;
  logic                    setup_last_ax;

  logic [16:0]             bnd_dist;
  axis_t                   pick;
  logic                    pick_neg;
  logic [TIME_BITS:0]      sum;
  logic [TIME_BITS-1:0]    sum_sat;
  logic [CELL_BITS-1:0]    cell_upd [3];
  logic                    last_step;

  assign org_in[0] = origin_x;
  assign org_in[1] = origin_y;
  assign org_in[2] = origin_z;
  assign dir_in[0] = dir_x;
  assign dir_in[1] = dir_y;
  assign dir_in[2] = dir_z;

  assign accept        = in_valid && in_ready;
  assign all_zero      = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
  assign out_free      = !out_valid || out_ready;
  assign setup_last_ax = (setup_ax == AX_Z);
  assign last_step     = (step == max_m1);

  vgrt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // distance to first boundary
  always_comb begin
    if (sgn[setup_ax] == SGN_MINUS) begin
      bnd_dist = {1'b0, frac[setup_ax]};
    end else begin
      bnd_dist = 17'h10000 - {1'b0, frac[setup_ax]};
    end
  end

  // axis choice, ties to y then z
  always_comb begin
    if (tnext[AX_X] < tnext[AX_Y]) begin
      pick = (tnext[AX_X] < tnext[AX_Z]) ? AX_X : AX_Z;
    end else begin
      pick = (tnext[AX_Y] < tnext[AX_Z]) ? AX_Y : AX_Z;
    end
    pick_neg = (sgn[pick] == SGN_MINUS);
    sum      = {1'b0, tnext[pick]} + {1'b0, tinc[pick]};
    sum_sat  = sum[TIME_BITS] ? TIME_NEVER : sum[TIME_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      cell_upd[i] = cur_cell[i];
    end
    cell_upd[pick] = pick_neg ? (cur_cell[pick] - 1'b1) : (cur_cell[pick] + 1'b1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = all_zero ? ST_FLAG : ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sgn[setup_ax] == SGN_NONE) begin
          if (setup_last_ax) begin
            state_next = ST_STEP;
          end
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = (setup_inc && setup_last_ax) ? ST_STEP : ST_SETUP;
        end
      end
      ST_STEP: begin
        if (out_free && last_step) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLAG: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    do_never         = 1'b0;
    do_div_write     = 1'b0;
    do_step          = 1'b0;
    do_flag          = 1'b0;
    div_req.start    = 1'b0;
    div_req.divisor  = mag[setup_ax];
    div_req.dividend = setup_inc ? INC_DIVIDEND : {bnd_dist, 15'b0};
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SETUP: begin
        if (sgn[setup_ax] == SGN_NONE) begin
          do_never = 1'b1;
        end else begin
          div_req.start = 1'b1;
        end
      end
      ST_DIV: begin
        do_div_write = div_rsp.done;
      end
      ST_STEP: begin
        do_step = out_free;
      end
      ST_FLAG: begin
        do_flag = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      max_m1 <= STEP_BITS'(16);
    end else begin
      state <= state_next;
      if (cfg_write) begin
        max_m1 <= cfg_wdata;
      end
    end
  end

  // per-axis ray state
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      setup_ax  <= AX_X;
      setup_inc <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        cur_cell[i] <= '0;
        tnext[i]    <= '0;
        tinc[i]     <= '0;
        sgn[i]      <= SGN_NONE;
      end
    end else begin
      if (accept) begin
        step      <= '0;
        setup_ax  <= AX_X;
        setup_inc <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          cur_cell[i] <= CELL_BITS'(org_in[i][31:16]);
          frac[i]     <= org_in[i][15:0];
          if (dir_in[i] == '0) begin
            sgn[i] <= SGN_NONE;
            mag[i] <= '0;
          end else if (dir_in[i][15]) begin
            sgn[i] <= SGN_MINUS;
            mag[i] <= 16'd0 - dir_in[i];
          end else begin
            sgn[i] <= SGN_PLUS;
            mag[i] <= dir_in[i];
          end
        end
      end
      if (do_never) begin
        tnext[setup_ax] <= TIME_NEVER;
        tinc[setup_ax]  <= TIME_NEVER;
        if (!setup_last_ax) begin
          setup_ax <= axis_t'(setup_ax + 2'd1);
        end
      end
      if (do_div_write) begin
        if (setup_inc) begin
          tinc[setup_ax] <= TIME_BITS'(div_rsp.quotient);
          setup_inc      <= 1'b0;
          if (!setup_last_ax) begin
            setup_ax <= axis_t'(setup_ax + 2'd1);
          end
        end else begin
          tnext[setup_ax] <= TIME_BITS'(div_rsp.quotient);
          setup_inc       <= 1'b1;
        end
      end
      if (do_step) begin
        cur_cell[pick] <= cell_upd[pick];
        tnext[pick]    <= sum_sat;
        step           <= step + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_step || do_flag) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      cell_x       <= cell_upd[AX_X][15:0];
      cell_y       <= cell_upd[AX_Y][15:0];
      cell_z       <= cell_upd[AX_Z][15:0];
      entry_face   <= {pick, pick_neg};
      step_number  <= step;
      no_direction <= 1'b0;
      last         <= last_step;
    end else if (do_flag) begin
      cell_x       <= '0;
      cell_y       <= '0;
      cell_z       <= '0;
      entry_face   <= '0;
      step_number  <= '0;
      no_direction <= 1'b1;
      last         <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/vgrt_checker.sv =====
// port-level checker for the voxel grid ray traversal unit, bound to the top level
// depends on voxel_grid_ray_traversal_unit_assert.svh
`include "voxel_grid_ray_traversal_unit_assert.svh"

module vgrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] cell_x,
  input logic [15:0] cell_y,
  input logic [15:0] cell_z,
  input logic [2:0]  entry_face,
  input logic [5:0]  step_number,
  input logic        no_direction,
  input logic        last
);

  logic [58:0] out_bits;
  logic [5:0]  step_inc;
  logic        xfer_more;

  assign out_bits  = {cell_x, cell_y, cell_z, entry_face, step_number, no_direction, last};
  assign step_inc  = step_number + 6'd1;
  assign xfer_more = out_valid && out_ready && !last;

  // stalled result holds
  `VGRT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_bits))

  // busy after an input transfer
  `VGRT_ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && in_ready, !in_ready)

  // flagged ray gives a single result
  `VGRT_ASSERT_IMPLY(a_flag_last, clk, rst, out_valid && no_direction, last)

  // a non-final result keeps the input closed
  `VGRT_ASSERT_IMPLY(a_ray_continues, clk, rst, out_valid && !last, !in_ready)

  // next result follows at once with the next step index
  `VGRT_ASSERT_NEXT(a_step_seq, clk, rst, xfer_more, out_valid && step_number == $past(step_inc))

endmodule

bind voxel_grid_ray_traversal_unit vgrt_checker u_vgrt_checker (.*);

// ===== test/voxel_grid_ray_traversal_unit_checker.sv =====
// scoreboard for the voxel grid ray traversal unit: watches the cfg, in and out channels,
// traces each accepted ray cell by cell and compares every out transfer in order
// depends on vgrt_pkg
module voxel_grid_ray_traversal_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] origin_z,
  input  logic [15:0] dir_x,
  input  logic [15:0] dir_y,
  input  logic [15:0] dir_z,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] cell_x,
  input  logic [15:0] cell_y,
  input  logic [15:0] cell_z,
  input  logic [2:0]  entry_face,
  input  logic [5:0]  step_number,
  input  logic        no_direction,
  input  logic        last,
  output int          pending,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import vgrt_pkg::*;

  localparam logic [5:0] STEPS_RESET = 6'd16;
  localparam int         MAX_PRINTS  = 40;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
    logic [2:0]  face;
    logic [5:0]  step;
    logic        nodir;
    logic        last;
  } cell_rec_t;

  cell_rec_t  cells_due[$];
  logic [5:0] steps_minus_one = STEPS_RESET;
  int         errs = 0;

  assign mismatch_count = errs;

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (errs < MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errs++;
  endtask

  // amanatides-woo walk of one ray, queues every cell it enters
  function automatic void trace_ray(input logic [2:0][31:0] org, input logic [2:0][15:0] dv);
    logic [2:0][15:0] cur_cell;
    logic [2:0][47:0] t_next;
    logic [2:0][47:0] t_inc;
    sgn_t             sgn [0:2];
    logic [16:0]      mag;
    logic [16:0]      bnd_dist;
    logic [63:0]      sum;
    axis_t            ax;
    logic             neg;
    int               count;
    cell_rec_t        rec;

    for (int i = 0; i < 3; i++) begin
      cur_cell[i] = org[i][31:16];
      if (dv[i] == 16'd0) begin
        sgn[i]    = SGN_NONE;
        t_next[i] = TIME_NEVER;
        t_inc[i]  = TIME_NEVER;
      end else begin
        if (dv[i][15]) begin
          mag      = 17'h10000 - {1'b0, dv[i]};
          bnd_dist = {1'b0, org[i][15:0]};
          sgn[i]   = SGN_MINUS;
        end else begin
          mag      = {1'b0, dv[i]};
          bnd_dist = 17'h10000 - {1'b0, org[i][15:0]};
          sgn[i]   = SGN_PLUS;
        end
        t_next[i] = 48'((64'(bnd_dist) << 15) / 64'(mag));
        t_inc[i]  = 48'((64'd1 << 31) / 64'(mag));
      end
    end

    if (sgn[0] == SGN_NONE && sgn[1] == SGN_NONE && sgn[2] == SGN_NONE) begin
      rec       = '0;
      rec.nodir = 1'b1;
      rec.last  = 1'b1;
      cells_due.push_back(rec);
      return;
    end

    count = int'(steps_minus_one) + 1;
    for (int k = 0; k < count; k++) begin
      // ties between x and y go to y, any tie with z goes to z
      if (t_next[AX_X] < t_next[AX_Y])
        ax = (t_next[AX_X] < t_next[AX_Z]) ? AX_X : AX_Z;
      else
        ax = (t_next[AX_Y] < t_next[AX_Z]) ? AX_Y : AX_Z;
      neg = (sgn[ax] == SGN_MINUS);
      cur_cell[ax] = neg ? cur_cell[ax] - 16'd1 : cur_cell[ax] + 16'd1;
      sum = 64'(t_next[ax]) + 64'(t_inc[ax]);
      t_next[ax] = (sum > 64'(TIME_NEVER)) ? TIME_NEVER : sum[47:0];

      rec.cx    = cur_cell[AX_X];
      rec.cy    = cur_cell[AX_Y];
      rec.cz    = cur_cell[AX_Z];
      rec.face  = {ax, neg};
      rec.step  = k[5:0];
      rec.nodir = 1'b0;
      rec.last  = (k == count - 1);
      cells_due.push_back(rec);
    end
  endfunction

  always @(posedge clk) begin
    cell_rec_t got;
    cell_rec_t want;

    if (rst) begin
      cells_due.delete();
      steps_minus_one = STEPS_RESET;
    end else begin
      if (out_valid && out_ready) begin
        got = {cell_x, cell_y, cell_z, entry_face, step_number, no_direction, last};
        if (cells_due.size() == 0) begin
          flag_mismatch("out transfer with no cell due", 16'({got.face, got.step}), 16'd0);
        end else begin
          want = cells_due.pop_front();
          if (got.cx != want.cx) flag_mismatch("cell_x", got.cx, want.cx);
          if (got.cy != want.cy) flag_mismatch("cell_y", got.cy, want.cy);
          if (got.cz != want.cz) flag_mismatch("cell_z", got.cz, want.cz);
          if (got.face != want.face)
            flag_mismatch("entry_face", 16'(got.face), 16'(want.face));
          if (got.step != want.step)
            flag_mismatch("step_number", 16'(got.step), 16'(want.step));
          if (got.nodir != want.nodir)
            flag_mismatch("no_direction", 16'(got.nodir), 16'(want.nodir));
          if (got.last != want.last)
            flag_mismatch("last", 16'(got.last), 16'(want.last));
        end
      end
      if (cfg_write)
        steps_minus_one = cfg_wdata;
      if (in_valid && in_ready)
        trace_ray({origin_z, origin_y, origin_x}, {dir_z, dir_y, dir_x});
    end
    pending <= cells_due.size();
  end

endmodule

// ===== test/voxel_grid_ray_traversal_unit_tb.sv =====
// testbench top for the voxel grid ray traversal unit: clock, reset, ray stimulus,
// step-count settings and random idling on both channels, verdict at the end
// depends on vgrt_pkg, voxel_grid_ray_traversal_unit and its checker
module voxel_grid_ray_traversal_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES     = 8;
  localparam int PHASE_RAYS = 56;
  localparam int DRAIN      = 200;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_write    = 1'b0;
  logic [5:0]         cfg_wdata    = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic signed [31:0] origin_x     = '0;
  logic signed [31:0] origin_y     = '0;
  logic signed [31:0] origin_z     = '0;
  logic signed [15:0] dir_x        = '0;
  logic signed [15:0] dir_y        = '0;
  logic signed [15:0] dir_z        = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [15:0] cell_x;
  logic signed [15:0] cell_y;
  logic signed [15:0] cell_z;
  logic [2:0]         entry_face;
  logic [5:0]         step_number;
  logic               no_direction;
  logic               last;

  int pending;
  int mismatch_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #6 clk = ~clk;

  voxel_grid_ray_traversal_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .origin_z     (origin_z),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_z       (cell_z),
    .entry_face   (entry_face),
    .step_number  (step_number),
    .no_direction (no_direction),
    .last         (last)
  );

  voxel_grid_ray_traversal_unit_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .origin_z       (origin_z),
    .dir_x          (dir_x),
    .dir_y          (dir_y),
    .dir_z          (dir_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cell_x         (cell_x),
    .cell_y         (cell_y),
    .cell_z         (cell_z),
    .entry_face     (entry_face),
    .step_number    (step_number),
    .no_direction   (no_direction),
    .last           (last),
    .pending        (pending),
    .mismatch_count (mismatch_count)
  );

  always @(posedge clk) begin
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                          input logic [15:0] dx, input logic [15:0] dy, input logic [15:0] dz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    origin_x <= ox;
    origin_y <= oy;
    origin_z <= oz;
    dir_x    <= dx;
    dir_y    <= dy;
    dir_z    <= dz;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_steps(input logic [5:0] value);
    cfg_write <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic void make_ray(output logic [2:0][31:0] org, output logic [2:0][15:0] dv);
    int shape;

    shape = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      org[i] = $urandom;
      case ($urandom_range(7))
        0: org[i][15:0]  = 16'h0000;
        1: org[i][15:0]  = 16'hFFFF;
        2: org[i][31:16] = 16'h7FFF;
        3: org[i][31:16] = 16'h8000;
        4: org[i][31:16] = 16'hFFFF;
        default: ;
      endcase
      case ($urandom_range(9))
        0: dv[i] = 16'h0000;
        1: dv[i] = 16'h8000;
        2: dv[i] = 16'h7FFF;
        3: dv[i] = $urandom_range(1) ? 16'h0001 : 16'hFFFF;
        4: dv[i] = 16'($signed(8'($urandom)));
        default: dv[i] = 16'($urandom);
      endcase
    end
    // some rays with no motion, some with equal slopes to force ties
    if (shape < 5) begin
      dv = '0;
    end else if (shape < 15) begin
      org[0][15:0] = 16'h0000;
      org[1][15:0] = 16'h0000;
      org[2][15:0] = 16'h0000;
      dv[1] = dv[0];
      if (shape < 10)
        dv[2] = dv[0];
    end
  endfunction

  initial begin
    logic [2:0][31:0] org;
    logic [2:0][15:0] dv;
    logic [5:0]       steps_plan [PHASES];

    steps_plan = '{6'd0, 6'd63, 6'd3, 6'd12, 6'd1, 6'd63, 6'd7, 6'd0};
    steps_plan[4] = 6'($urandom_range(63));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed rays at the reset step count
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h7FFF, 16'h0000, 16'h0000);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h8000, 16'h0000, 16'h0000);
    send_ray(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000);
    send_ray(32'h0003_4000, 32'h0000_0000, 32'hFFFE_0000, 16'h0000, 16'h7FFF, 16'h0000);
    send_ray(32'h0000_0000, 32'h0000_1000, 32'h0000_0000, 16'h0000, 16'h0000, 16'h8000);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h4000, 16'h4000, 16'h0000);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h4000, 16'h4000, 16'h4000);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'h4000, 16'h0000, 16'h4000);
    send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 16'h0001, 16'hFFFF, 16'h0000);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0001, 16'h0001, 16'h0001);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16'h8000, 16'h8000, 16'h8000);
    send_ray(32'h1234_5678, 32'h0000_FFFF, 32'h0000_0000, 16'h0001, 16'h8000, 16'h0000);
    send_ray(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 16'h0000, 16'h0000, 16'h0000);
    send_ray(32'h0001_0001, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 16'h0000, 16'h0000);
    send_ray(32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h0F0F_F0F0, 16'h7FFF, 16'h8001, 16'h3039);
    send_ray(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 16'h0001, 16'h0001, 16'h0001);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_steps(steps_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int n = 0; n < PHASE_RAYS; n++) begin
        make_ray(org, dv);
        send_ray(org[0], org[1], org[2], dv[0], dv[1], dv[2]);
      end
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0)
      $display("voxel_grid_ray_traversal_unit_tb: done, clean");
    else
      $display("voxel_grid_ray_traversal_unit_tb: done, errors");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("voxel_grid_ray_traversal_unit_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/vgrt_pkg.sv
hw/rtl/vgrt_div.sv
hw/rtl/voxel_grid_ray_traversal_unit.sv
hw/rtl/vgrt_checker.sv
test/voxel_grid_ray_traversal_unit_checker.sv
test/voxel_grid_ray_traversal_unit_tb.sv
